// ===== design/bgd_pkg.sv =====
// Shared types, register indexes and helpers for the button gesture detector.
package bgd_pkg;

    localparam int unsigned TIME_W    = 32;
    localparam int unsigned MS_W      = 16;
    localparam int unsigned PHASE_W   = 4;
    localparam int unsigned EVSEL_W   = 3;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 8;

    typedef enum logic [PHASE_W-1:0] {
        PH_OPEN     = 4'd0,
        PH_DEBOUNCE = 4'd1,
        PH_PRESS    = 4'd2,
        PH_CLICK    = 4'd3,
        PH_DOUBLE   = 4'd4,
        PH_LONG     = 4'd5,
        PH_STUCK    = 4'd6,
        PH_RELEASE  = 4'd7,
        PH_ACTION   = 4'd8
    } phase_t;

    typedef enum logic [EVSEL_W-1:0] {
        EVT_PRESS   = 3'd0,
        EVT_LONG    = 3'd1,
        EVT_CLICK   = 3'd2,
        EVT_DOUBLE  = 3'd3,
        EVT_RELEASE = 3'd4,
        EVT_NONE    = 3'd5
    } event_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACTIVE_LEVEL = 3'd0,
        REG_EVENT_SELECT = 3'd1,
        REG_DEBOUNCE_MS  = 3'd2,
        REG_LONG_PRESS   = 3'd3,
        REG_DOUBLE_CLICK = 3'd4,
        REG_RELEASE_MS   = 3'd5
    } reg_index_t;

    localparam logic [EVSEL_W-1:0] EVENT_SELECT_RST = EVT_CLICK;
    localparam logic [MS_W-1:0]    DEBOUNCE_RST     = 16'd50;
    localparam logic [MS_W-1:0]    LONG_PRESS_RST   = 16'd1000;
    localparam logic [MS_W-1:0]    DOUBLE_CLICK_RST = 16'd300;
    localparam logic [MS_W-1:0]    RELEASE_RST      = 16'd50;

    typedef struct packed {
        logic              active_level;
        logic [EVSEL_W-1:0] event_select;
        logic [MS_W-1:0]   debounce_ms;
        logic [MS_W-1:0]   long_press_ms;
        logic [MS_W-1:0]   double_click_ms;
        logic [MS_W-1:0]   release_ms;
    } cfg_t;

    // true when the selected event stands for this phase
    function automatic logic event_hits(input logic [EVSEL_W-1:0] evsel, input phase_t ph);
        logic hit;
        begin
            case (ph)
                PH_PRESS:   hit = (evsel == EVT_PRESS);
                PH_LONG:    hit = (evsel == EVT_LONG);
                PH_CLICK:   hit = (evsel == EVT_CLICK);
                PH_DOUBLE:  hit = (evsel == EVT_DOUBLE);
                PH_RELEASE: hit = (evsel == EVT_RELEASE);
                default:    hit = 1'b0;
            endcase
            return hit;
        end
    endfunction

endpackage

// ===== design/bgd_fsm.sv =====
// Gesture state machine: phase, previous phase and time mark, one step per poll.
module bgd_fsm
    import bgd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              pin_level,
    input  logic [TIME_W-1:0] now_ms,
    input  cfg_t              cfg,
    output logic              fire,
    output phase_t            phase_next
);

    phase_t            phase_reg;
    phase_t            prev_reg;
    logic [TIME_W-1:0] mark_reg;

    logic              on;
    logic [TIME_W-1:0] elapsed;
    logic              ge_debounce;
    logic              ge_long;
    logic              ge_double;
    logic              gt_release;

    assign on          = (pin_level == cfg.active_level);
    assign elapsed     = now_ms - mark_reg;
    assign ge_debounce = (elapsed >= {16'd0, cfg.debounce_ms});
    assign ge_long     = (elapsed >= {16'd0, cfg.long_press_ms});
    assign ge_double   = (elapsed >= {16'd0, cfg.double_click_ms});
    assign gt_release  = (elapsed >  {16'd0, cfg.release_ms});

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_OPEN:
            begin
                if (on)
                    phase_next = PH_DEBOUNCE;
            end
            PH_DEBOUNCE:
            begin
                if (!on)
                    phase_next = PH_OPEN;
                else if (ge_debounce)
                    phase_next = PH_PRESS;
            end
            PH_PRESS:
            begin
                if (event_hits(cfg.event_select, PH_PRESS))
                    phase_next = PH_ACTION;
                else if (!on)
                    phase_next = PH_CLICK;
                else if (ge_long)
                    phase_next = PH_LONG;
            end
            PH_LONG:
            begin
                if (!on)
                    phase_next = PH_RELEASE;
                else if (event_hits(cfg.event_select, PH_LONG))
                    phase_next = PH_ACTION;
            end
            PH_STUCK:
            begin
                if (!on)
                    phase_next = PH_RELEASE;
            end
            PH_CLICK:
            begin
                if (!on && ge_double)
                    phase_next = PH_ACTION;
                else if (on && !ge_double && ge_debounce)
                    phase_next = PH_DOUBLE;
            end
            PH_DOUBLE, PH_RELEASE:
                phase_next = PH_ACTION;
            PH_ACTION:
            begin
                if (gt_release)
                    phase_next = on ? PH_STUCK : PH_OPEN;
            end
            default:
                phase_next = phase_reg;
        endcase
    end

    // outputs
    always_comb
    begin
        case (phase_reg)
            PH_ACTION: fire = gt_release && event_hits(cfg.event_select, prev_reg);
            default:   fire = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_OPEN;
            prev_reg  <= PH_OPEN;
            mark_reg  <= '0;
        end
        else if (advance && (phase_next != phase_reg))
        begin
            prev_reg  <= phase_reg;
            phase_reg <= phase_next;
            mark_reg  <= now_ms;
        end
    end

    a_fire_in_action: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> (phase_reg == PH_ACTION))
        else $error("fire outside take-action phase");

    a_mark_on_move: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (phase_next != phase_reg)) |=>
            (mark_reg == $past(now_ms)) && (prev_reg == $past(phase_reg)))
        else $error("phase change did not record time and previous phase");

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(phase_reg) && $stable(mark_reg))
        else $error("state moved without a poll");

endmodule

// ===== design/button_gesture_detector.sv =====
// Top level of the button gesture detector: config registers, stream ports, result register.
//
//  channel   | signals                                   | payload
//  ----------+-------------------------------------------+-------------------------------
//  poll in   | s_tvalid s_tready s_tdata[39:0]           | pin_level, now_ms
//  result out| m_tvalid m_tready m_tdata[7:0]            | fire, gesture_state
//  config    | cfg_valid cfg_ready cfg_index cfg_data    | register index, write data
//
//  One poll per cycle while the result register can take one; each result is registered
//  and appears in the cycle after its poll is taken. The single result register sets the
//  rate: a poll is taken whenever it is empty or being drained in the same cycle. Reset
//  returns the phase to open, the time mark to zero and the config registers to their
//  defaults, but not the result data. A stalled output holds its result and stalls the input.
module button_gesture_detector
    import bgd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [0] pin_level, [32:1] now_ms, [39:33] zero
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [0] fire, [4:1] gesture_state, [7:5] zero
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [MS_W-1:0]        cfg_data
);

    cfg_t   cfg_reg;
    logic   out_valid_reg;
    logic   out_fire_reg;
    phase_t out_phase_reg;

    logic   accept;
    logic   fire;
    phase_t phase_next;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_level    <= 1'b0;
            cfg_reg.event_select    <= EVENT_SELECT_RST;
            cfg_reg.debounce_ms     <= DEBOUNCE_RST;
            cfg_reg.long_press_ms   <= LONG_PRESS_RST;
            cfg_reg.double_click_ms <= DOUBLE_CLICK_RST;
            cfg_reg.release_ms      <= RELEASE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ACTIVE_LEVEL: cfg_reg.active_level    <= cfg_data[0];
                REG_EVENT_SELECT: cfg_reg.event_select    <= cfg_data[EVSEL_W-1:0];
                REG_DEBOUNCE_MS:  cfg_reg.debounce_ms     <= cfg_data;
                REG_LONG_PRESS:   cfg_reg.long_press_ms   <= cfg_data;
                REG_DOUBLE_CLICK: cfg_reg.double_click_ms <= cfg_data;
                REG_RELEASE_MS:   cfg_reg.release_ms      <= cfg_data;
                default:          ;
            endcase
        end
    end

    bgd_fsm u_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (accept),
        .pin_level  (s_tdata[0]),
        .now_ms     (s_tdata[TIME_W:1]),
        .cfg        (cfg_reg),
        .fire       (fire),
        .phase_next (phase_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_fire_reg  <= fire;
            out_phase_reg <= phase_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_phase_reg, out_fire_reg};

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("accepted poll produced no result");

    a_fire_leaves_action: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_fire_reg) |->
            (out_phase_reg == PH_STUCK || out_phase_reg == PH_OPEN))
        else $error("fire result without leaving take-action phase");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !accept)
        else $error("pending result overwritten");

endmodule

// ===== test/button_gesture_detector_tb.sv =====
// Self-checking testbench for button_gesture_detector: directed gestures, random walks, stalls.
module button_gesture_detector_tb
    import bgd_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned MAX_SHOWN   = 10;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic   fire;
        phase_t state;
    } poll_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;   // [0] pin_level, [32:1] now_ms, [39:33] zero
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;        // [0] fire, [4:1] gesture_state, [7:5] zero
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [MS_W-1:0]        cfg_data = '0;

    // predictor state
    cfg_t         regs;
    phase_t       phase;
    phase_t       prev_phase;
    logic [31:0]  mark_ms;
    poll_result_t pending_results[$];

    logic [31:0]  clock_ms = '0;
    bit           idle_on = 1'b1;
    int unsigned  hold_cycles = 0;
    int unsigned  polls_sent = 0;
    int unsigned  results_seen = 0;
    int unsigned  mismatches = 0;
    int unsigned  cycles = 0;

    button_gesture_detector u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic event_matches(input phase_t left);
        logic hit;
        case (regs.event_select)
            EVT_PRESS:   hit = (left == PH_PRESS);
            EVT_LONG:    hit = (left == PH_LONG);
            EVT_CLICK:   hit = (left == PH_CLICK);
            EVT_DOUBLE:  hit = (left == PH_DOUBLE);
            EVT_RELEASE: hit = (left == PH_RELEASE);
            default:     hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic poll_result_t advance_gesture(input logic pin, input logic [31:0] now);
        logic         on;
        logic         moved;
        logic [31:0]  elapsed;
        phase_t       nxt;
        poll_result_t res;
        on      = (pin == regs.active_level);
        elapsed = now - mark_ms;
        nxt     = phase;
        moved   = 1'b0;
        res     = '0;
        case (phase)
            PH_OPEN:
                if (on) begin nxt = PH_DEBOUNCE; moved = 1'b1; end
            PH_DEBOUNCE:
                if (!on) begin nxt = PH_OPEN; moved = 1'b1; end
                else if (elapsed >= {16'd0, regs.debounce_ms})
                begin
                    nxt = PH_PRESS; moved = 1'b1;
                end
            PH_PRESS:
                if (regs.event_select == EVT_PRESS) begin nxt = PH_ACTION; moved = 1'b1; end
                else if (!on) begin nxt = PH_CLICK; moved = 1'b1; end
                else if (elapsed >= {16'd0, regs.long_press_ms})
                begin
                    nxt = PH_LONG; moved = 1'b1;
                end
            PH_LONG:
                if (!on) begin nxt = PH_RELEASE; moved = 1'b1; end
                else if (regs.event_select == EVT_LONG) begin nxt = PH_ACTION; moved = 1'b1; end
            PH_STUCK:
                if (!on) begin nxt = PH_RELEASE; moved = 1'b1; end
            PH_CLICK:
                if (!on && elapsed >= {16'd0, regs.double_click_ms})
                begin
                    nxt = PH_ACTION; moved = 1'b1;
                end
                else if (on && elapsed < {16'd0, regs.double_click_ms}
                         && elapsed >= {16'd0, regs.debounce_ms})
                begin
                    nxt = PH_DOUBLE; moved = 1'b1;
                end
            PH_DOUBLE, PH_RELEASE:
            begin
                nxt = PH_ACTION; moved = 1'b1;
            end
            PH_ACTION:
                if (elapsed > {16'd0, regs.release_ms})
                begin
                    res.fire = event_matches(prev_phase);
                    nxt      = on ? PH_STUCK : PH_OPEN;
                    moved    = 1'b1;
                end
            default: ;
        endcase
        if (moved)
        begin
            prev_phase = phase;
            phase      = nxt;
            mark_ms    = now;
        end
        res.state = phase;
        return res;
    endfunction

    task automatic send_poll(input logic pin, input logic [31:0] now);
        int unsigned gap;
        gap = idle_on ? $urandom_range(13) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, now, pin};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pending_results.push_back(advance_gesture(pin, now));
        polls_sent++;
    endtask

    // pressed selects the configured active level
    task automatic poll(input bit pressed, input logic [31:0] dt);
        clock_ms = clock_ms + dt;
        send_poll(pressed ? regs.active_level : ~regs.active_level, clock_ms);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (results_seen < polls_sent) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MS_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_ACTIVE_LEVEL: regs.active_level    = data[0];
            REG_EVENT_SELECT: regs.event_select    = data[EVSEL_W-1:0];
            REG_DEBOUNCE_MS:  regs.debounce_ms     = data;
            REG_LONG_PRESS:   regs.long_press_ms   = data;
            REG_DOUBLE_CLICK: regs.double_click_ms = data;
            REG_RELEASE_MS:   regs.release_ms      = data;
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic al, input logic [EVSEL_W-1:0] ev,
                                input logic [MS_W-1:0] deb, input logic [MS_W-1:0] lp,
                                input logic [MS_W-1:0] dc, input logic [MS_W-1:0] rel);
        logic [MS_W-1:0] junk;
        junk = MS_W'($urandom);
        wait_idle();
        write_reg(REG_ACTIVE_LEVEL, {junk[15:1], al});
        write_reg(REG_EVENT_SELECT, {junk[15:3], ev});
        write_reg(REG_DEBOUNCE_MS, deb);
        write_reg(REG_LONG_PRESS, lp);
        write_reg(REG_DOUBLE_CLICK, dc);
        write_reg(REG_RELEASE_MS, rel);
        // out-of-range index must be ignored
        write_reg(junk[0] ? REG_SPARE_HI : REG_SPARE_LO, MS_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [MS_W-1:0] pick_ms();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 12) return '0;
        if (r < 20) return '1;
        if (r < 60) return MS_W'($urandom_range(20));
        return MS_W'($urandom_range(400));
    endfunction

    // biased random walk: timing aimed at the threshold of the current phase
    task automatic wander();
        logic [31:0] since;
        logic [31:0] thr;
        logic [31:0] target;
        int unsigned bias;
        int unsigned pick;
        bit          pressed;
        since = clock_ms - mark_ms;
        case (phase)
            PH_OPEN:     begin thr = 0;                       bias = 70; end
            PH_DEBOUNCE: begin thr = 32'(regs.debounce_ms);   bias = 85; end
            PH_PRESS:    begin thr = 32'(regs.long_press_ms); bias = 60; end
            PH_CLICK:
            begin
                thr  = $urandom_range(1) ? 32'(regs.debounce_ms) : 32'(regs.double_click_ms);
                bias = 45;
            end
            PH_ACTION:   begin thr = 32'(regs.release_ms);    bias = 30; end
            default:     begin thr = $urandom_range(100);     bias = 50; end
        endcase
        pressed = ($urandom_range(99) < bias);
        pick    = $urandom_range(15);
        if (pick == 15)
        begin
            clock_ms = $urandom;
            send_poll(pressed ? regs.active_level : ~regs.active_level, clock_ms);
        end
        else if (pick >= 13)
            poll(pressed, 0);
        else
        begin
            case (pick)
                0, 1:    target = thr - 1;
                2, 3:    target = thr;
                4, 5:    target = thr + 1;
                default: target = $urandom_range(thr + thr / 2 + 5);
            endcase
            poll(pressed, (target >= since) ? target - since : 32'($urandom_range(3)));
        end
    endtask

    task automatic test_click_defaults();
        poll(1, 0);
        poll(1, 50);
        poll(0, 10);
        poll(0, 300);
        poll(0, 51);
    endtask

    task automatic test_double_click();
        apply_config(1'b0, EVT_DOUBLE, 16'd50, 16'd1000, 16'd300, 16'd50);
        poll(1, 5);
        poll(1, 50);
        poll(0, 10);
        poll(1, 50);
        poll(0, 1);
        poll(0, 51);
    endtask

    task automatic test_long_then_release();
        apply_config(1'b1, EVT_LONG, 16'd50, 16'd1000, 16'd300, 16'd50);
        poll(1, 5);
        poll(1, 50);
        poll(1, 1000);
        poll(0, 3);
        poll(0, 1);
        poll(0, 51);
    endtask

    task automatic test_press_stuck_zero_times();
        apply_config(1'b1, EVT_PRESS, 16'd0, 16'd0, 16'd0, 16'd0);
        poll(1, 5);
        poll(1, 0);
        poll(0, 0);
        poll(1, 1);
        poll(0, 2);
        poll(0, 0);
        poll(0, 1);
    endtask

    task automatic test_backpressure();
        wait_idle();
        idle_on     = 1'b0;
        hold_cycles = 80;
        repeat (30) wander();
        idle_on = 1'b1;
    endtask

    task automatic test_random_phases();
        int unsigned p;
        logic [MS_W-1:0] deb;
        logic [MS_W-1:0] lp;
        logic [MS_W-1:0] dc;
        logic [MS_W-1:0] rel;
        for (p = 0; p < 16; p++)
        begin
            deb = pick_ms();
            lp  = pick_ms();
            dc  = pick_ms();
            rel = pick_ms();
            if (p == 0) begin deb = '0; lp = '0; dc = '0; rel = '0; end
            if (p == 1) begin deb = '1; lp = '1; dc = '1; rel = '1; end
            apply_config(1'($urandom_range(1)),
                         (p < 8) ? EVSEL_W'(p) : EVSEL_W'($urandom_range(7)),
                         deb, lp, dc, rel);
            idle_on = (p % 4 != 3);
            if (p == 5)
                clock_ms = 32'hFFFF_FFC0;
            repeat (66) wander();
        end
        idle_on = 1'b1;
    endtask

    task automatic note_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("mismatch %s: expected %0d, got %0d", field, want, got);
    endtask

    always @(posedge clk)
    begin : check_results
        poll_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                note_mismatch("unexpected result, state", 0, 32'(m_tdata[4:1]));
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[0] !== want.fire)
                    note_mismatch("fire", 32'(want.fire), 32'(m_tdata[0]));
                if (m_tdata[4:1] !== want.state)
                    note_mismatch("gesture_state", 32'(want.state), 32'(m_tdata[4:1]));
            end
        end
    end

    initial
    begin : sink
        int unsigned gap;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                gap         = hold_cycles;
                hold_cycles = 0;
            end
            else
                gap = idle_on ? $urandom_range(13) : 0;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("button_gesture_detector verification failed");
            $finish;
        end
    end

    initial
    begin
        regs       = '{active_level: 1'b0, event_select: EVENT_SELECT_RST,
                       debounce_ms: DEBOUNCE_RST, long_press_ms: LONG_PRESS_RST,
                       double_click_ms: DOUBLE_CLICK_RST, release_ms: RELEASE_RST};
        phase      = PH_OPEN;
        prev_phase = PH_OPEN;
        mark_ms    = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_click_defaults();
        test_double_click();
        test_long_then_release();
        test_press_stuck_zero_times();
        test_backpressure();
        test_random_phases();

        wait_idle();
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            mismatches += pending_results.size();
            $display("%0d expected results never arrived", pending_results.size());
        end
        if (mismatches == 0)
            $display("button_gesture_detector verification clean");
        else
            $display("button_gesture_detector verification failed");
        $finish;
    end

endmodule
